FILE: rtl/assert_macros.svh
// assertion macros used by the rtl (included only by kfi_core)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KFI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kfi check failed");

// next-cycle implication
`define KFI_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kfi check failed");

`endif

FILE: rtl/kfi_pkg.sv
// package with types, widths and codes of the keyframe segment interpolator
package kfi_pkg;

  localparam int NEWTON_STEPS_DEF = 8;
  localparam int BISECT_STEPS_DEF = 16;

  localparam int ONE_Q16 = 65536;

  localparam int VAL_W   = 32;
  localparam int FRAME_W = 24;
  localparam int FRAC_W  = 17;
  localparam int CO_W    = 40;
  localparam int CX_W    = 22;
  localparam int MB_W    = 18;
  localparam int PROD_W  = CO_W + MB_W;
  localparam int EW      = 22;
  localparam int DNUM_W  = 38;
  localparam int DDEN_W  = 25;

  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_BEZIER = 2'd2;

  typedef struct packed {
    logic [1:0]               mode;
    logic [FRAME_W-1:0]       prev_frame;
    logic [FRAME_W-1:0]       next_frame;
    logic signed [VAL_W-1:0]  prev_value;
    logic signed [VAL_W-1:0]  next_value;
    logic signed [VAL_W-1:0]  out_dx;
    logic signed [VAL_W-1:0]  out_dy;
    logic signed [VAL_W-1:0]  in_dx;
    logic signed [VAL_W-1:0]  in_dy;
    logic [FRAC_W-1:0]        t_frac;
  } kfi_item_t;

endpackage

FILE: rtl/kfi_div.sv
// radix-2 restoring signed divider, truncating quotient, one bit per cycle
module kfi_div
  import kfi_pkg::*;
#(
  parameter int NUM_W = DNUM_W,
  parameter int DEN_W = DDEN_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic             neg;
  logic [NUM_W-1:0] nq;
  logic [DEN_W-1:0] dmag;
  logic [DEN_W-1:0] rem;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_dif;
  logic             ge;
  logic [DEN_W-1:0] rem_next;
  logic [NUM_W-1:0] nq_next;

  assign rem_sh   = {rem, nq[NUM_W-1]};
  assign rem_dif  = rem_sh - {1'b0, dmag};
  assign ge       = rem_sh >= {1'b0, dmag};
  assign rem_next = ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  assign nq_next  = {nq[NUM_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        nq  <= nq_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          quo  <= neg ? -signed'(nq_next) : signed'(nq_next);
        end
      end else if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        neg  <= num[NUM_W-1] ^ den[DEN_W-1];
        nq   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dmag <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      end
    end
  end

endmodule

FILE: rtl/kfi_core.sv
// sequencer with one shared multiplier and the divider: hold, linear and bezier solve
`include "assert_macros.svh"
module kfi_core
  import kfi_pkg::*;
#(
  parameter int NEWTON_STEPS = NEWTON_STEPS_DEF,
  parameter int BISECT_STEPS = BISECT_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  kfi_item_t               item,
  output logic                    idle,
  output logic                    res_valid,
  output logic signed [VAL_W-1:0] res_value,
  input  logic                    res_ack
);

  localparam int MAXS = (NEWTON_STEPS > BISECT_STEPS) ? NEWTON_STEPS : BISECT_STEPS;
  localparam int K_W  = $clog2(MAXS + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SETUP = 4'd1;
  localparam logic [3:0] ST_LIN   = 4'd2;
  localparam logic [3:0] ST_LINF  = 4'd3;
  localparam logic [3:0] ST_DIV1  = 4'd4;
  localparam logic [3:0] ST_DIV2  = 4'd5;
  localparam logic [3:0] ST_COEF1 = 4'd6;
  localparam logic [3:0] ST_COEF2 = 4'd7;
  localparam logic [3:0] ST_M1    = 4'd8;
  localparam logic [3:0] ST_M2    = 4'd9;
  localparam logic [3:0] ST_M3    = 4'd10;
  localparam logic [3:0] ST_M4    = 4'd11;
  localparam logic [3:0] ST_NDIV  = 4'd12;
  localparam logic [3:0] ST_DONE  = 4'd13;

  localparam logic [1:0] POLY_X  = 2'd0;
  localparam logic [1:0] POLY_DX = 2'd1;
  localparam logic [1:0] POLY_Y  = 2'd2;

  localparam logic signed [CO_W+1:0] VMAX = (CO_W+2)'(2147483647);
  localparam logic signed [CO_W+1:0] VMIN = -VMAX - 1;
  localparam logic signed [CX_W-1:0] ONE_CX = CX_W'(ONE_Q16);

  logic [3:0]               st;
  logic [1:0]               poly;
  logic                     bis;
  logic [K_W-1:0]           k;
  logic [1:0]               mode;
  logic [FRAC_W-1:0]        t;
  logic [FRAC_W-1:0]        u;
  logic [FRAC_W-1:0]        lo;
  logic [FRAC_W-1:0]        hi;
  logic signed [VAL_W-1:0]  v0;
  logic signed [VAL_W-1:0]  v1;
  logic signed [VAL_W-1:0]  odx;
  logic signed [VAL_W-1:0]  ody;
  logic signed [VAL_W-1:0]  idx;
  logic signed [VAL_W-1:0]  idy;
  logic signed [DDEN_W-1:0] dur;
  logic [FRAC_W-1:0]        p1x;
  logic [FRAC_W-1:0]        p2x;
  logic signed [CX_W-1:0]   ax;
  logic signed [CX_W-1:0]   bx;
  logic signed [CX_W-1:0]   cx;
  logic signed [CO_W-1:0]   ay;
  logic signed [CO_W-1:0]   by;
  logic signed [CO_W-1:0]   cy;
  logic signed [EW-1:0]     e;
  logic signed [PROD_W-1:0] prod;
  logic signed [VAL_W-1:0]  res;

  logic signed [CO_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [CO_W-1:0]   prod_lo;
  logic signed [CO_W-1:0]   a_term;
  logic signed [CO_W-1:0]   b_term;
  logic signed [CO_W-1:0]   c_term;
  logic signed [CO_W-1:0]   m3_val;
  logic signed [CO_W-1:0]   t_s;
  logic signed [CO_W-1:0]   ex;
  logic                     ex_small;
  logic                     dv_small;
  logic                     t_gt;
  logic [FRAC_W-1:0]        lo_n;
  logic [FRAC_W-1:0]        hi_n;
  logic [FRAC_W:0]          mid_sum;
  logic signed [CO_W+1:0]   y_val;
  logic signed [PROD_W-1:0] lin_sh;
  logic signed [CO_W+1:0]   lin_val;
  logic signed [CX_W-1:0]   p1s;
  logic signed [CX_W-1:0]   p2s;
  logic signed [DNUM_W-1:0] e_num;
  logic signed [DNUM_W+1:0] u_dif;

  logic                     div_start;
  logic signed [DNUM_W-1:0] div_num;
  logic signed [DDEN_W-1:0] div_den;
  logic                     div_done;
  logic signed [DNUM_W-1:0] div_quo;

  function automatic logic [FRAC_W-1:0] clamp_unit(input logic signed [DNUM_W+1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > (DNUM_W+2)'(ONE_Q16)) begin
      return FRAC_W'(ONE_Q16);
    end else begin
      return v[FRAC_W-1:0];
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [CO_W+1:0] v);
    if (v > VMAX) begin
      return VAL_W'(VMAX);
    end else if (v < VMIN) begin
      return VAL_W'(VMIN);
    end else begin
      return v[VAL_W-1:0];
    end
  endfunction

  kfi_div #(
    .NUM_W(DNUM_W),
    .DEN_W(DDEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  assign prod_sh = prod >>> 16;
  assign prod_lo = signed'(prod_sh[CO_W-1:0]);
  assign t_s     = signed'(CO_W'(t));
  assign p1s     = signed'(CX_W'(p1x));
  assign p2s     = signed'(CX_W'(p2x));

  always_comb begin
    case (poly)
      POLY_X: begin
        a_term = CO_W'(ax);
        b_term = CO_W'(bx);
        c_term = CO_W'(cx);
      end
      POLY_DX: begin
        a_term = CO_W'(CO_W'(ax) * 3);
        b_term = CO_W'(CO_W'(bx) * 2);
        c_term = CO_W'(cx);
      end
      default: begin
        a_term = ay;
        b_term = by;
        c_term = cy;
      end
    endcase
  end

  assign m3_val = prod_lo + c_term;

  always_comb begin
    mul_b = signed'(MB_W'(u));
    case (st)
      ST_LIN: begin
        mul_a = CO_W'(v1) - CO_W'(v0);
        mul_b = signed'(MB_W'(t));
      end
      ST_M1:   mul_a = a_term;
      ST_M2:   mul_a = prod_lo + b_term;
      ST_M3:   mul_a = m3_val;
      default: mul_a = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign ex       = prod_lo - t_s;
  assign ex_small = (ex >= -1) && (ex <= 1);
  assign dv_small = (m3_val >= -1) && (m3_val <= 1);
  assign t_gt     = t_s > prod_lo;
  assign lo_n     = t_gt ? u : lo;
  assign hi_n     = t_gt ? hi : u;
  assign mid_sum  = {1'b0, lo_n} + {1'b0, hi_n};
  assign y_val    = (CO_W+2)'(signed'(prod_sh[CO_W:0])) + (CO_W+2)'(v0);
  assign lin_sh   = (prod + PROD_W'(32768)) >>> 16;
  assign lin_val  = (CO_W+2)'(signed'(lin_sh[CO_W:0])) + (CO_W+2)'(v0);
  assign e_num    = DNUM_W'(e) <<< 16;
  assign u_dif    = (DNUM_W+2)'(signed'({1'b0, u})) - (DNUM_W+2)'(div_quo);

  always_comb begin
    div_start = 1'b0;
    div_num   = DNUM_W'(odx);
    div_den   = dur;
    case (st)
      ST_SETUP: div_start = (mode == MODE_BEZIER) && (dur > 0);
      ST_DIV1: begin
        div_start = div_done;
        div_num   = DNUM_W'(idx);
      end
      ST_M3: begin
        div_start = (poly == POLY_DX) && !dv_small;
        div_num   = e_num;
        div_den   = DDEN_W'(m3_val);
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ST_IDLE;
      poly <= POLY_X;
      bis  <= 1'b0;
      k    <= '0;
    end else begin
      case (st)
        ST_IDLE: begin
          if (start) begin
            mode <= item.mode;
            t    <= item.t_frac;
            v0   <= item.prev_value;
            v1   <= item.next_value;
            odx  <= item.out_dx;
            ody  <= item.out_dy;
            idx  <= item.in_dx;
            idy  <= item.in_dy;
            dur  <= signed'(DDEN_W'(item.next_frame)) - signed'(DDEN_W'(item.prev_frame));
            st   <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          case (mode)
            MODE_HOLD: begin
              res <= v0;
              st  <= ST_DONE;
            end
            MODE_BEZIER: begin
              if (dur > 0) begin
                st <= ST_DIV1;
              end else begin
                res <= v1;
                st  <= ST_DONE;
              end
            end
            default: st <= ST_LIN;
          endcase
        end
        ST_LIN:  st <= ST_LINF;
        ST_LINF: begin
          res <= sat_val(lin_val);
          st  <= ST_DONE;
        end
        ST_DIV1: begin
          if (div_done) begin
            p1x <= clamp_unit((DNUM_W+2)'(div_quo));
            st  <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            p2x <= clamp_unit((DNUM_W+2)'(div_quo) + (DNUM_W+2)'(ONE_Q16));
            st  <= ST_COEF1;
          end
        end
        ST_COEF1: begin
          cx <= CX_W'(p1s * 3);
          bx <= CX_W'((p2s - p1s) * 3 - p1s * 3);
          cy <= CO_W'(CO_W'(ody) * 3);
          by <= CO_W'((CO_W'(v1) + CO_W'(idy) - CO_W'(v0) - CO_W'(ody) * 2) * 3);
          st <= ST_COEF2;
        end
        ST_COEF2: begin
          ax   <= ONE_CX - cx - bx;
          ay   <= CO_W'(v1) - CO_W'(v0) - cy - by;
          u    <= t;
          k    <= '0;
          bis  <= 1'b0;
          poly <= POLY_X;
          st   <= ST_M1;
        end
        ST_M1: st <= ST_M2;
        ST_M2: st <= ST_M3;
        ST_M3: begin
          if (poly == POLY_DX) begin
            if (dv_small) begin
              lo   <= '0;
              hi   <= FRAC_W'(ONE_Q16);
              u    <= t;
              k    <= '0;
              bis  <= 1'b1;
              poly <= POLY_X;
              st   <= ST_M1;
            end else begin
              st <= ST_NDIV;
            end
          end else begin
            st <= ST_M4;
          end
        end
        ST_M4: begin
          if (poly == POLY_Y) begin
            res <= sat_val(y_val);
            st  <= ST_DONE;
          end else begin
            st <= ST_M1;
            if (ex_small) begin
              poly <= POLY_Y;
            end else if (!bis) begin
              e    <= ex[EW-1:0];
              poly <= POLY_DX;
            end else begin
              lo <= lo_n;
              hi <= hi_n;
              u  <= mid_sum[FRAC_W:1];
              k  <= k + 1'b1;
              if (k == K_W'(BISECT_STEPS - 1)) begin
                poly <= POLY_Y;
              end
            end
          end
        end
        ST_NDIV: begin
          if (div_done) begin
            st <= ST_M1;
            if (k == K_W'(NEWTON_STEPS - 1)) begin
              lo   <= '0;
              hi   <= FRAC_W'(ONE_Q16);
              u    <= t;
              k    <= '0;
              bis  <= 1'b1;
              poly <= POLY_X;
            end else begin
              u    <= clamp_unit(u_dif);
              k    <= k + 1'b1;
              poly <= POLY_X;
            end
          end
        end
        ST_DONE: begin
          if (res_ack) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  assign idle      = (st == ST_IDLE);
  assign res_valid = (st == ST_DONE);
  assign res_value = res;

  `KFI_ASSERT_IMP(a_u_range, clk, rst, st == ST_M1, u <= FRAC_W'(ONE_Q16))
  `KFI_ASSERT_IMP(a_bracket, clk, rst, (st == ST_M1) && bis, (lo <= u) && (u <= hi))
  `KFI_ASSERT_NXT(a_done_hold, clk, rst, (st == ST_DONE) && !res_ack, st == ST_DONE)

endmodule

FILE: rtl/keyframe_segment_interpolator_top.sv
// Keyframe segment interpolator: one input beat gives one result beat. Bezier with
// a positive frame span first runs two radix-2 divisions for the x control points,
// then each Newton step evaluates x and x' on the one shared multiplier and then a
// radix-2 division, each bisection step evaluates x, and a final y evaluation gives
// the value; hold and a span that is not positive give a key value directly. The
// next input beat is taken once the sequencer is back at rest; a finished result
// waits in the output register without holding up the sequencer beyond its own
// hand-off.
module keyframe_segment_interpolator_top
  import kfi_pkg::*;
#(
  parameter int NEWTON_STEPS = NEWTON_STEPS_DEF,
  parameter int BISECT_STEPS = BISECT_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               mode,
  input  logic [FRAME_W-1:0]       prev_frame,
  input  logic [FRAME_W-1:0]       next_frame,
  input  logic signed [VAL_W-1:0]  prev_value,
  input  logic signed [VAL_W-1:0]  next_value,
  input  logic signed [VAL_W-1:0]  out_dx,
  input  logic signed [VAL_W-1:0]  out_dy,
  input  logic signed [VAL_W-1:0]  in_dx,
  input  logic signed [VAL_W-1:0]  in_dy,
  input  logic [FRAC_W-1:0]        t_frac,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  result_value
);

  kfi_item_t               item;
  logic                    core_idle;
  logic                    res_valid;
  logic signed [VAL_W-1:0] res_value;
  logic                    res_ack;
  logic                    accept;

  // fraction above one saturates to one
  always_comb begin
    item.mode       = mode;
    item.prev_frame = prev_frame;
    item.next_frame = next_frame;
    item.prev_value = prev_value;
    item.next_value = next_value;
    item.out_dx     = out_dx;
    item.out_dy     = out_dy;
    item.in_dx      = in_dx;
    item.in_dy      = in_dy;
    item.t_frac     = (t_frac > FRAC_W'(ONE_Q16)) ? FRAC_W'(ONE_Q16) : t_frac;
  end

  assign in_stall = !core_idle;
  assign accept   = in_valid && !in_stall;
  assign res_ack  = res_valid && (!out_valid || !out_stall);

  kfi_core #(
    .NEWTON_STEPS(NEWTON_STEPS),
    .BISECT_STEPS(BISECT_STEPS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .item     (item),
    .idle     (core_idle),
    .res_valid(res_valid),
    .res_value(res_value),
    .res_ack  (res_ack)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ack) begin
      out_valid    <= 1'b1;
      result_value <= res_value;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: verif/keyframe_segment_interpolator_checker.sv
// checker module: predicts interpolated values from observed input beats and compares results
module keyframe_segment_interpolator_checker
  import kfi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [1:0]              mode,
  input  logic [FRAME_W-1:0]      prev_frame,
  input  logic [FRAME_W-1:0]      next_frame,
  input  logic signed [VAL_W-1:0] prev_value,
  input  logic signed [VAL_W-1:0] next_value,
  input  logic signed [VAL_W-1:0] out_dx,
  input  logic signed [VAL_W-1:0] out_dy,
  input  logic signed [VAL_W-1:0] in_dx,
  input  logic signed [VAL_W-1:0] in_dy,
  input  logic [FRAC_W-1:0]       t_frac,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [VAL_W-1:0] result_value,
  output int                      fail_count,
  output int                      pending
);

  logic signed [VAL_W-1:0] expected_values[$];

  assign pending = expected_values.size();

  function automatic longint fshr(longint v);
    return v >>> 16;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint eval_cubic(longint a, longint b, longint c, longint u);
    longint h;
    h = fshr(a * u);
    h = fshr((h + b) * u);
    return fshr((h + c) * u);
  endfunction

  function automatic longint bezier_value(longint pf, longint nf, longint v0, longint v1,
                                          longint odx, longint ody, longint idx,
                                          longint idy, longint t);
    longint d, p1x, p2x, ax, bx, cx, ay, by, cy, u, lo, hi, e, dv, x;
    d = nf - pf;
    if (d <= 0) return v1;
    p1x = clampl(odx / d, 0, ONE_Q16);
    p2x = clampl(ONE_Q16 + idx / d, 0, ONE_Q16);
    cx = 3 * p1x;
    bx = 3 * (p2x - p1x) - cx;
    ax = ONE_Q16 - cx - bx;
    cy = 3 * ody;
    by = 3 * (v1 + idy - v0 - 2 * ody);
    ay = v1 - v0 - cy - by;
    u = t;
    for (int i = 0; i < NEWTON_STEPS_DEF; i++) begin
      e = eval_cubic(ax, bx, cx, u) - t;
      if (absl(e) <= 1) return eval_cubic(ay, by, cy, u) + v0;
      dv = fshr((fshr(3 * ax * u) + 2 * bx) * u) + cx;
      if (absl(dv) <= 1) break;
      u = clampl(u - (e * ONE_Q16) / dv, 0, ONE_Q16);
    end
    lo = 0;
    hi = ONE_Q16;
    u = t;
    for (int i = 0; i < BISECT_STEPS_DEF; i++) begin
      x = eval_cubic(ax, bx, cx, u);
      if (absl(x - t) <= 1) return eval_cubic(ay, by, cy, u) + v0;
      if (t > x) lo = u;
      else hi = u;
      u = (lo + hi) >>> 1;
    end
    return eval_cubic(ay, by, cy, u) + v0;
  endfunction

  function automatic logic signed [VAL_W-1:0] interpolate(kfi_item_t it);
    longint t, v0, v1, r;
    t = clampl(longint'(it.t_frac), 0, ONE_Q16);
    v0 = it.prev_value;
    v1 = it.next_value;
    if (it.mode == MODE_HOLD) r = v0;
    else if (it.mode == MODE_BEZIER)
      r = bezier_value(longint'(it.prev_frame), longint'(it.next_frame), v0, v1,
                       it.out_dx, it.out_dy, it.in_dx, it.in_dy, t);
    else r = v0 + fshr((v1 - v0) * t + 32768);
    r = clampl(r, -64'sd2147483648, 64'sd2147483647);
    return r[VAL_W-1:0];
  endfunction

  task automatic report(string what, logic signed [VAL_W-1:0] got,
                        logic signed [VAL_W-1:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_values.push_back(interpolate({mode, prev_frame, next_frame, prev_value,
            next_value, out_dx, out_dy, in_dx, in_dy, t_frac}));
      if (out_valid && !out_stall) begin
        if (expected_values.size() == 0) report("unexpected beat", result_value, 0);
        else if (result_value !== expected_values[0])
          report("result_value", result_value, expected_values.pop_front());
        else void'(expected_values.pop_front());
      end
    end
  end

endmodule

FILE: verif/keyframe_segment_interpolator_top_test.sv
// testbench top: drives keyframe segments with random gaps and stalls, gives the verdict
module keyframe_segment_interpolator_top_test;
  import kfi_pkg::*;

  logic                    clk = 0;
  logic                    rst = 1;
  logic                    in_valid = 0;
  logic                    in_stall;
  logic [1:0]              mode = '0;
  logic [FRAME_W-1:0]      prev_frame = '0;
  logic [FRAME_W-1:0]      next_frame = '0;
  logic signed [VAL_W-1:0] prev_value = '0;
  logic signed [VAL_W-1:0] next_value = '0;
  logic signed [VAL_W-1:0] out_dx = '0;
  logic signed [VAL_W-1:0] out_dy = '0;
  logic signed [VAL_W-1:0] in_dx = '0;
  logic signed [VAL_W-1:0] in_dy = '0;
  logic [FRAC_W-1:0]       t_frac = '0;
  logic                    out_valid;
  logic                    out_stall = 0;
  logic signed [VAL_W-1:0] result_value;
  int                      fail_count;
  int                      pending;
  bit                      stim_done = 0;

  always #10 clk = ~clk;

  keyframe_segment_interpolator_top dut (.*);
  keyframe_segment_interpolator_checker chk (.*);

  task automatic send(kfi_item_t it);
    repeat ($urandom_range(0, 8)) @(negedge clk);
    {mode, prev_frame, next_frame, prev_value, next_value, out_dx, out_dy, in_dx, in_dy,
     t_frac} = it;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 0;
  endtask

  function automatic logic [31:0] wide_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'(int'($urandom_range(0, 2000000)) - 1000000) <<< 8;
    endcase
  endfunction

  function automatic kfi_item_t random_segment();
    kfi_item_t it;
    int unsigned dur;
    it.mode = $urandom_range(0, 9) < 6 ? MODE_BEZIER : 2'($urandom_range(0, 3));
    it.prev_frame = FRAME_W'($urandom());
    dur = $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(1, 200);
    it.next_frame = $urandom_range(0, 15) == 0 ? FRAME_W'($urandom()) :
                    it.prev_frame + 24'(dur);
    it.prev_value = wide_value();
    it.next_value = wide_value();
    it.out_dy = wide_value();
    it.in_dy = wide_value();
    dur = 32'(it.next_frame - it.prev_frame);
    it.out_dx = $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, dur[15:0]) * 32'd1;
    it.in_dx = $urandom_range(0, 7) == 0 ? $urandom() : -($urandom_range(0, dur[15:0]));
    it.t_frac = $urandom_range(0, 9) == 0 ? FRAC_W'($urandom()) :
                FRAC_W'($urandom_range(0, ONE_Q16));
    return it;
  endfunction

  initial begin
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) out_stall <= 1;
      else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else out_stall <= 0;
    end
  end

  initial begin
    kfi_item_t it;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    for (int m = 0; m < 4; m++) begin
      it = '0;
      it.mode = 2'(m);
      it.next_frame = 24'd24;
      it.prev_value = 32'h80000000;
      it.next_value = 32'h7fffffff;
      it.t_frac = 17'h1ffff;
      it.out_dx = 32'h7fffffff;
      it.in_dx = 32'h80000000;
      it.out_dy = 32'h7fffffff;
      it.in_dy = 32'h80000000;
      send(it);
      it.t_frac = '0;
      it.prev_value = 32'h7fffffff;
      it.next_value = 32'h80000000;
      send(it);
      it.t_frac = FRAC_W'(ONE_Q16);
      send(it);
      it.prev_frame = 24'hffffff;
      it.next_frame = '0;
      it.t_frac = 17'd32768;
      send(it);
      it.prev_frame = 24'h123456;
      it.next_frame = 24'h123456;
      send(it);
    end
    it = random_segment();
    it.mode = MODE_BEZIER;
    it.prev_frame = '0;
    it.next_frame = 24'hffffff;
    it.out_dx = 32'h55555555;
    it.in_dx = 32'hd5555555;
    send(it);
    for (int n = 0; n < 1150; n++) begin
      if (n == 500) wait (pending == 0);
      send(random_segment());
    end
    wait (pending == 0);
    repeat (600) @(posedge clk);
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/kfi_pkg.sv
rtl/kfi_div.sv
rtl/kfi_core.sv
rtl/keyframe_segment_interpolator_top.sv
verif/keyframe_segment_interpolator_checker.sv
verif/keyframe_segment_interpolator_top_test.sv
